// ===== hdl/mm64_pkg.sv =====
package mm64_pkg;

    // port width of every factor, the modulus and the residue
    localparam int IO_WIDTH      = 64;
    // factors and modulus are taken in their low OPERAND_WIDTH bits (8..64, even)
    localparam int OPERAND_WIDTH = 64;
    localparam int HALF_WIDTH    = OPERAND_WIDTH / 2;
    localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;

    // four partial products of the half-width multiplier
    localparam int MUL_STEPS     = 4;
    localparam int MUL_CNT_W     = $clog2(MUL_STEPS + 1);

    // one reduction step per product bit
    localparam int RED_CNT_W     = $clog2(PROD_WIDTH);

    // weight of a partial product, in units of HALF_WIDTH bits
    typedef enum logic [1:0] {
        PP_POS_LOW  = 2'd0,
        PP_POS_MID  = 2'd1,
        PP_POS_HIGH = 2'd2
    } t_pp_pos;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_RED  = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

    // handshake between the sequencer and one arithmetic unit
    typedef struct packed {
        logic start;
    } t_unit_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

// ===== hdl/mm64_mul.sv =====
module mm64_mul import mm64_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_unit_ctl                i_ctl,
    input  logic [OPERAND_WIDTH-1:0] i_a,
    input  logic [OPERAND_WIDTH-1:0] i_b,
    output t_unit_sts                o_sts,
    output logic [PROD_WIDTH-1:0]    o_product
);

    logic                     r_busy;
    logic [MUL_CNT_W-1:0]     r_cnt;
    logic [OPERAND_WIDTH-1:0] r_a;
    logic [OPERAND_WIDTH-1:0] r_b;
    logic [OPERAND_WIDTH-1:0] r_pp;
    t_pp_pos                  r_pp_pos;
    logic                     r_pp_vld;
    logic [PROD_WIDTH-1:0]    r_acc;

    logic [HALF_WIDTH-1:0]    a_half;
    logic [HALF_WIDTH-1:0]    b_half;
    logic [PROD_WIDTH-1:0]    pp_ext;
    logic [PROD_WIDTH-1:0]    pp_shifted;
    logic                     issue;
    logic                     done;

    // cnt bit 0 picks the half of a, bit 1 the half of b
    assign a_half = r_cnt[0] ? r_a[OPERAND_WIDTH-1:HALF_WIDTH] : r_a[HALF_WIDTH-1:0];
    assign b_half = r_cnt[1] ? r_b[OPERAND_WIDTH-1:HALF_WIDTH] : r_b[HALF_WIDTH-1:0];
    assign issue  = r_busy && (r_cnt < MUL_CNT_W'(MUL_STEPS));
    assign done   = r_busy && (r_cnt == MUL_CNT_W'(MUL_STEPS)) && !r_pp_vld;

    assign pp_ext = PROD_WIDTH'(r_pp);

    always_comb begin
        unique case (r_pp_pos)
            PP_POS_LOW:  pp_shifted = pp_ext;
            PP_POS_MID:  pp_shifted = pp_ext << HALF_WIDTH;
            PP_POS_HIGH: pp_shifted = pp_ext << OPERAND_WIDTH;
            default:     pp_shifted = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= '0;
            r_pp_vld <= 1'b0;
        end else if (i_ctl.start) begin
            r_busy   <= 1'b1;
            r_cnt    <= '0;
            r_pp_vld <= 1'b0;
        end else begin
            if (done) begin
                r_busy <= 1'b0;
            end
            if (issue) begin
                r_cnt <= r_cnt + MUL_CNT_W'(1);
            end
            r_pp_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else begin
            if (issue) begin
                r_pp     <= OPERAND_WIDTH'(a_half) * OPERAND_WIDTH'(b_half);
                r_pp_pos <= t_pp_pos'(2'(r_cnt[0]) + 2'(r_cnt[1]));
            end
            if (r_pp_vld) begin
                r_acc <= r_acc + pp_shifted;
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = done;
    assign o_product  = r_acc;

endmodule

// ===== hdl/mm64_red.sv =====
module mm64_red import mm64_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_unit_ctl                i_ctl,
    input  logic [PROD_WIDTH-1:0]    i_product,
    input  logic [OPERAND_WIDTH-1:0] i_modulus,
    output t_unit_sts                o_sts,
    output logic [OPERAND_WIDTH-1:0] o_rem
);

    logic                     r_busy;
    logic                     r_done;
    logic [RED_CNT_W-1:0]     r_cnt;
    logic [PROD_WIDTH-1:0]    r_prod;
    logic [OPERAND_WIDTH-1:0] r_rem;

    logic [OPERAND_WIDTH+1:0] diff;
    logic [OPERAND_WIDTH-1:0] n_rem;
    logic                     last;

    // shifted remainder with the carried-out top bit, less the modulus
    assign diff = {1'b0, r_rem, r_prod[PROD_WIDTH-1]} - (OPERAND_WIDTH+2)'(i_modulus);
    assign n_rem = diff[OPERAND_WIDTH+1] ? {r_rem[OPERAND_WIDTH-2:0], r_prod[PROD_WIDTH-1]}
                                         : diff[OPERAND_WIDTH-1:0];
    assign last  = (r_cnt == RED_CNT_W'(PROD_WIDTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last;
            if (r_busy) begin
                r_cnt <= r_cnt + RED_CNT_W'(1);
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_prod <= i_product;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_prod <= r_prod << 1;
            r_rem  <= n_rem;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_rem      = r_rem;

endmodule

// ===== hdl/modular_multiply_64_top.sv =====
// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+--------------------------------
// input    | in        | i_in_valid / o_in_stall    | i_multiplicand, i_multiplier
// output   | out       | o_out_valid / i_out_stall  | o_residue
// config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_modulus
//
// one transaction passes from acceptance through the multiply, which runs one half-width
// partial product per cycle through a single multiplier, then through the reduction, one
// product bit per cycle through one shift-and-subtract unit, and then back to idle before
// the next acceptance; the residue is loaded into the output register as the sequencer
// returns to idle. synchronous active-low reset clears control state; the modulus
// resets to 1. o_in_stall is high while a transaction is in progress; the result
// waits in an output register, so the next transaction can start while it is not taken.
module modular_multiply_64_top import mm64_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [IO_WIDTH-1:0] i_multiplicand,
    input  logic [IO_WIDTH-1:0] i_multiplier,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [IO_WIDTH-1:0] o_residue,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [IO_WIDTH-1:0] i_cfg_modulus
);

    t_state                   r_state;
    t_state                   n_state;
    logic [OPERAND_WIDTH-1:0] r_modulus;
    logic                     r_out_vld;
    logic [OPERAND_WIDTH-1:0] r_residue;

    t_unit_ctl                mul_ctl;
    t_unit_sts                mul_sts;
    t_unit_ctl                red_ctl;
    t_unit_sts                red_sts;
    logic [PROD_WIDTH-1:0]    product;
    logic [OPERAND_WIDTH-1:0] rem;

    logic                     in_acc;
    logic                     out_free;
    logic                     load_out;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_vld || !i_out_stall;

    always_comb begin
        n_state       = r_state;
        mul_ctl.start = 1'b0;
        red_ctl.start = 1'b0;
        load_out      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    mul_ctl.start = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                if (mul_sts.done) begin
                    red_ctl.start = 1'b1;
                    n_state       = S_RED;
                end
            end
            S_RED: begin
                if (red_sts.done) begin
                    if (out_free) begin
                        load_out = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_state  = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_modulus <= OPERAND_WIDTH'(1);
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_modulus <= i_cfg_modulus[OPERAND_WIDTH-1:0];
            end
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // a zero modulus gives a zero residue
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_residue <= (r_modulus == '0) ? '0 : rem;
        end
    end

    mm64_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mul_ctl),
        .i_a       (i_multiplicand[OPERAND_WIDTH-1:0]),
        .i_b       (i_multiplier[OPERAND_WIDTH-1:0]),
        .o_sts     (mul_sts),
        .o_product (product)
    );

    mm64_red u_red (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (red_ctl),
        .i_product (product),
        .i_modulus (r_modulus),
        .o_sts     (red_sts),
        .o_rem     (rem)
    );

    assign o_in_stall  = !(r_state == S_IDLE) || mul_sts.busy || red_sts.busy;
    assign o_out_valid = r_out_vld;
    assign o_residue   = IO_WIDTH'(r_residue);
    assign o_cfg_ready = 1'b1;

endmodule

// ===== tb/tb.sv =====
module tb;
    import mm64_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                CLK_HALF     = 5;
    localparam int                RESET_CYCLES = 6;
    localparam int                IDLE_GAP     = 8;
    localparam int                TAIL_CYCLES  = 300;
    localparam int                CYCLE_LIMIT  = 1_000_000;
    localparam int                PHASE_ITEMS  = 50;
    localparam logic [IO_WIDTH-1:0] ALL_ONES   = {IO_WIDTH{1'b1}};
    localparam logic [IO_WIDTH-1:0] OP_MASK    = ALL_ONES >> (IO_WIDTH - OPERAND_WIDTH);
    localparam logic [IO_WIDTH-1:0] TOP_BIT    = {1'b1, {(IO_WIDTH-1){1'b0}}};

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [IO_WIDTH-1:0] i_multiplicand;
    logic [IO_WIDTH-1:0] i_multiplier;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [IO_WIDTH-1:0] o_residue;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [IO_WIDTH-1:0] i_cfg_modulus;

    modular_multiply_64_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_multiplicand (i_multiplicand),
        .i_multiplier   (i_multiplier),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_residue      (o_residue),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_modulus  (i_cfg_modulus)
    );

    typedef struct {
        logic                set_mod;
        logic [IO_WIDTH-1:0] modulus;
        logic [IO_WIDTH-1:0] multiplicand;
        logic [IO_WIDTH-1:0] multiplier;
        logic                known;
        logic [IO_WIDTH-1:0] residue;
    } t_directed_row;

    logic [IO_WIDTH-1:0] expected_residues[$];
    logic [IO_WIDTH-1:0] cur_modulus;
    int                  in_idle_pct;
    int                  out_stall_pct;
    int                  error_count;
    int                  residues_checked;
    int                  items_sent;
    int                  modulus_settings;
    int                  cycle_count;
    t_directed_row       directed_rows[$];

    always #CLK_HALF i_clk = ~i_clk;

    // restoring shift-and-subtract over the full double-width product
    function automatic logic [IO_WIDTH-1:0] mod_product(input logic [IO_WIDTH-1:0] a,
                                                        input logic [IO_WIDTH-1:0] b,
                                                        input logic [IO_WIDTH-1:0] m);
        logic [IO_WIDTH-1:0]   am;
        logic [IO_WIDTH-1:0]   bm;
        logic [IO_WIDTH-1:0]   mm;
        logic [2*IO_WIDTH-1:0] prod;
        logic [IO_WIDTH:0]     rem;
        am = a & OP_MASK;
        bm = b & OP_MASK;
        mm = m & OP_MASK;
        if (mm == '0) begin
            return '0;
        end
        prod = {{IO_WIDTH{1'b0}}, am} * {{IO_WIDTH{1'b0}}, bm};
        rem  = '0;
        for (int k = 2*IO_WIDTH-1; k >= 0; k--) begin
            rem = {rem[IO_WIDTH-1:0], prod[k]};
            if (rem >= {1'b0, mm}) begin
                rem = rem - {1'b0, mm};
            end
        end
        return rem[IO_WIDTH-1:0];
    endfunction

    function automatic logic [IO_WIDTH-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // operands biased toward the edges of the modulus and the field
    function automatic logic [IO_WIDTH-1:0] pick_operand(input logic [IO_WIDTH-1:0] m);
        case ($urandom_range(9))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return IO_WIDTH'($urandom_range(255));
            3:       return m;
            4:       return m - 1;
            5:       return m + IO_WIDTH'($urandom_range(3));
            6:       return TOP_BIT >> $urandom_range(IO_WIDTH-1);
            default: return rand_word();
        endcase
    endfunction

    function automatic logic [IO_WIDTH-1:0] pick_modulus();
        logic [IO_WIDTH-1:0] m;
        case ($urandom_range(5))
            0:       m = IO_WIDTH'($urandom_range(255));
            1:       m = ALL_ONES - IO_WIDTH'($urandom_range(3));
            2:       m = rand_word() >> $urandom_range(IO_WIDTH-1);
            3:       m = rand_word() | TOP_BIT;
            default: m = rand_word();
        endcase
        if (m == '0) begin
            m = IO_WIDTH'(1);
        end
        return m;
    endfunction

    // config writes only once every pending residue is back
    task automatic load_modulus(input logic [IO_WIDTH-1:0] value);
        while (expected_residues.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (IDLE_GAP) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid   = 1'b1;
        i_cfg_modulus = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cur_modulus = value;
        modulus_settings++;
        @(negedge i_clk);
        i_cfg_valid   = 1'b0;
        i_cfg_modulus = rand_word();
    endtask

    task automatic send_item(input logic [IO_WIDTH-1:0] a,
                             input logic [IO_WIDTH-1:0] b,
                             input logic                known,
                             input logic [IO_WIDTH-1:0] residue);
        logic [IO_WIDTH-1:0] want;
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid     = 1'b0;
            i_multiplicand = rand_word();
            i_multiplier   = rand_word();
            @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_multiplicand = a;
        i_multiplier   = b;
        do @(posedge i_clk); while (o_in_stall);
        want              = known ? residue : mod_product(a, b, cur_modulus);
        expected_residues = {expected_residues, want};
        items_sent++;
    endtask

    task automatic add_row(input logic                set_mod,
                           input logic [IO_WIDTH-1:0] modulus,
                           input logic [IO_WIDTH-1:0] a,
                           input logic [IO_WIDTH-1:0] b,
                           input logic                known,
                           input logic [IO_WIDTH-1:0] residue);
        t_directed_row row;
        row.set_mod      = set_mod;
        row.modulus      = modulus;
        row.multiplicand = a;
        row.multiplier   = b;
        row.known        = known;
        row.residue      = residue;
        directed_rows    = {directed_rows, row};
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= i_rst_n && ($urandom_range(99) < out_stall_pct);
    end

    always @(posedge i_clk) begin
        logic [IO_WIDTH-1:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_residues.size() == 0) begin
                $error("residue with no pending transaction: got %h", o_residue);
                error_count++;
            end else begin
                want = expected_residues.pop_front();
                residues_checked++;
                if (o_residue !== want) begin
                    $error("residue mismatch: expected %h, actual %h", want, o_residue);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d residues outstanding",
                     cycle_count, expected_residues.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        logic [IO_WIDTH-1:0] m;
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_multiplicand   = '0;
        i_multiplier     = '0;
        i_out_stall      = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_modulus    = '0;
        cur_modulus      = IO_WIDTH'(1);
        in_idle_pct      = 0;
        out_stall_pct    = 0;
        error_count      = 0;
        residues_checked = 0;
        items_sent       = 0;
        modulus_settings = 0;
        cycle_count      = 0;

        // modulus of one straight out of reset
        add_row(1'b0, '0, ALL_ONES, ALL_ONES, 1'b1, '0);
        add_row(1'b0, '0, '0, '0, 1'b1, '0);
        // largest modulus: all ones is congruent to zero
        add_row(1'b1, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, '0);
        add_row(1'b0, '0, '0, ALL_ONES, 1'b1, '0);
        add_row(1'b0, '0, 64'd1, 64'd1, 1'b1, 64'd1);
        add_row(1'b0, '0, ALL_ONES - 1, ALL_ONES - 1, 1'b1, 64'd1);
        add_row(1'b0, '0, TOP_BIT, 64'd2, 1'b1, 64'd1);
        add_row(1'b0, '0, 64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, '0);
        add_row(1'b1, 64'd7, 64'd1, 64'd5, 1'b1, 64'd5);
        add_row(1'b0, '0, 64'd3, 64'd3, 1'b1, 64'd2);
        add_row(1'b0, '0, ALL_ONES, ALL_ONES, 1'b0, '0);
        add_row(1'b0, '0, 64'd7, 64'h1234_5678_9ABC_DEF0, 1'b1, '0);
        add_row(1'b1, TOP_BIT, ALL_ONES, ALL_ONES, 1'b1, 64'd1);
        add_row(1'b0, '0, TOP_BIT >> 1, 64'd2, 1'b1, '0);
        add_row(1'b0, '0, 64'hDEAD_BEEF_CAFE_F00D, 64'h0123_4567_89AB_CDEF, 1'b0, '0);
        add_row(1'b1, 64'd2, ALL_ONES, ALL_ONES, 1'b1, 64'd1);
        add_row(1'b0, '0, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, '0);
        add_row(1'b1, ALL_ONES - 1, ALL_ONES, ALL_ONES, 1'b1, 64'd1);
        add_row(1'b0, '0, '0, 64'd5, 1'b1, '0);
        add_row(1'b0, '0, 64'h8000_0000_0000_0001, ALL_ONES - 2, 1'b0, '0);
        add_row(1'b1, 64'd1, 64'hFEDC_BA98_7654_3210, 64'h0F1E_2D3C_4B5A_6978, 1'b1, '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].set_mod) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
                load_modulus(directed_rows[i].modulus);
            end
            send_item(directed_rows[i].multiplicand, directed_rows[i].multiplier,
                      directed_rows[i].known, directed_rows[i].residue);
        end

        // idle patterns: none, sender, receiver, both lightly
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1:       begin in_idle_pct = 64; out_stall_pct = 0;  end
                2:       begin in_idle_pct = 0;  out_stall_pct = 64; end
                default: begin in_idle_pct = 9;  out_stall_pct = 9;  end
            endcase
            for (int part = 0; part < 2; part++) begin
                m = (phase == 3 && part == 1) ? ALL_ONES : pick_modulus();
                @(negedge i_clk);
                i_in_valid = 1'b0;
                load_modulus(m);
                repeat (PHASE_ITEMS) begin
                    send_item(pick_operand(cur_modulus), pick_operand(cur_modulus), 1'b0, '0);
                end
            end
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_residues.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d transactions, checked %0d residues", items_sent, residues_checked);
        $display("across %0d modulus settings and four idle/stall patterns", modulus_settings);
        if (error_count == 0 && expected_residues.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
